/* rtl/vafu_pkg.sv */
// ----------------------------------------------------------------------------
// vafu_pkg
// Shared types, constants and saturation helpers for the vertical
// altitude/velocity fusion unit.
// ----------------------------------------------------------------------------
package vafu_pkg;

  // field widths
  localparam int QUAT_FRAC_BITS = 14;
  localparam int ROT_SHIFT      = 2 * QUAT_FRAC_BITS;
  localparam int ACC_W          = 19;
  localparam int Q_W            = 16;
  localparam int ALT_W          = 25;
  localparam int TIME_W         = 32;
  localparam int WACC_W         = 20;
  localparam int VEL_W          = 22;
  localparam int TAU_W          = 24;
  localparam int GAP_W          = 20;

  // physical constants and limits
  localparam int GRAVITY_MM = 9810;
  localparam int US_PER_S   = 1000000;
  localparam int ACC_LIM    = 500000;
  localparam int VEL_LIM    = 2000000;
  localparam int ALT_LO     = -1000000;
  localparam int ALT_HI     = 16000000;

  // divider geometry: magnitude bits and radix-4 iteration count
  localparam int DIV_W      = 52;
  localparam int DIV_STEPS  = DIV_W / 2;

  // queue between front and back
  localparam int FQ_DEPTH   = 2;
  localparam int FQ_PTR_W   = $clog2(FQ_DEPTH);

  // result status codes
  typedef enum logic [1:0] {
    ST_INIT   = 2'd0,
    ST_UPDATE = 2'd1,
    ST_SKIP   = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TAU_BARO = 2'd0,
    CFG_TAU_VEL  = 2'd1,
    CFG_TAU_ALT  = 2'd2,
    CFG_MAX_GAP  = 2'd3
  } cfg_idx_t;

  // quaternion component select codes
  localparam logic [1:0] QS_W = 2'd0;
  localparam logic [1:0] QS_X = 2'd1;
  localparam logic [1:0] QS_Y = 2'd2;
  localparam logic [1:0] QS_Z = 2'd3;

  // quaternion product order: xx yy zz xy xz yz xw yw zw
  localparam int NUM_QP = 9;
  localparam logic [1:0] QP_A [NUM_QP] = '{QS_X, QS_Y, QS_Z, QS_X, QS_X, QS_Y, QS_X, QS_Y, QS_Z};
  localparam logic [1:0] QP_B [NUM_QP] = '{QS_X, QS_Y, QS_Z, QS_Y, QS_Z, QS_Z, QS_W, QS_W, QS_W};

  typedef struct packed {
    logic [TAU_W-1:0] tau_baro;
    logic [TAU_W-1:0] tau_vel;
    logic [TAU_W-1:0] tau_alt;
    logic [GAP_W-1:0] max_gap;
  } cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic signed [WACC_W-1:0] wx;
    logic signed [WACC_W-1:0] wy;
    logic signed [WACC_W-1:0] wz;
    logic signed [ALT_W-1:0]  baro;
    logic [GAP_W-1:0]         dt;
    status_t                  status;
  } fq_item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_QPROD,
    F_ROT,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLASS,
    B_MUL1,
    B_MUL2,
    B_DSTART,
    B_DWAIT,
    B_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    P_SPD,
    P_IMU,
    P_VEL,
    P_PRD,
    P_ALT
  } phase_t;

  function automatic logic signed [WACC_W-1:0] sat_acc(input logic signed [27:0] v);
    logic signed [WACC_W-1:0] r;
    if (v < -ACC_LIM) r = WACC_W'(-ACC_LIM);
    else if (v > ACC_LIM) r = WACC_W'(ACC_LIM);
    else r = v[WACC_W-1:0];
    return r;
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [DIV_W:0] v);
    logic signed [VEL_W-1:0] r;
    if (v < -VEL_LIM) r = VEL_W'(-VEL_LIM);
    else if (v > VEL_LIM) r = VEL_W'(VEL_LIM);
    else r = v[VEL_W-1:0];
    return r;
  endfunction

  function automatic logic signed [ALT_W-1:0] sat_alt(input logic signed [DIV_W:0] v);
    logic signed [ALT_W-1:0] r;
    if (v < ALT_LO) r = ALT_W'(ALT_LO);
    else if (v > ALT_HI) r = ALT_W'(ALT_HI);
    else r = v[ALT_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/vafu_fifo.sv */
// ----------------------------------------------------------------------------
// vafu_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module vafu_fifo
  import vafu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  fq_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output fq_item_t head
);

  fq_item_t              mem_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]   wr_ptr_r;
  logic [FQ_PTR_W-1:0]   rd_ptr_r;
  logic [FQ_PTR_W:0]     cnt_r;

  assign full  = (cnt_r == (FQ_PTR_W+1)'(FQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == FQ_PTR_W'(FQ_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == FQ_PTR_W'(FQ_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) cnt_r <= cnt_r + 1'b1;
      else if (!(push && !full) && (pop && !empty)) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

/* rtl/vafu_front.sv */
// ----------------------------------------------------------------------------
// vafu_front
// Accepts an item, rotates the acceleration into the world frame with one
// shared multiplier, classifies the time gap and queues the result.
// ----------------------------------------------------------------------------
module vafu_front
  import vafu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ACC_W-1:0]  in_body_accel_x,
  input  logic signed [ACC_W-1:0]  in_body_accel_y,
  input  logic signed [ACC_W-1:0]  in_body_accel_z,
  input  logic signed [Q_W-1:0]    in_quat_w,
  input  logic signed [Q_W-1:0]    in_quat_x,
  input  logic signed [Q_W-1:0]    in_quat_y,
  input  logic signed [Q_W-1:0]    in_quat_z,
  input  logic signed [ALT_W-1:0]  in_baro_altitude_mm,
  input  logic [TIME_W-1:0]        in_timestamp_us,
  input  logic [GAP_W-1:0]         max_gap,
  output logic                     push_valid,
  output fq_item_t                 push_item,
  input  logic                     push_ready
);

  front_state_t state_r, state_nxt;
  logic [4:0]               step_r;
  logic signed [ACC_W-1:0]  ax_r, ay_r, az_r;
  logic signed [Q_W-1:0]    qw_r, qx_r, qy_r, qz_r;
  logic signed [ALT_W-1:0]  baro_r;
  logic [TIME_W-1:0]        ts_r;
  logic signed [31:0]       p_r [NUM_QP];
  logic signed [53:0]       sx_r, sy_r, sz_r;
  logic                     started_r;
  logic [TIME_W-1:0]        last_ts_r;

  logic signed [33:0]       pe [NUM_QP];
  logic signed [33:0]       mul_a;
  logic signed [ACC_W-1:0]  mul_b;
  logic signed [52:0]       prod;
  logic [3:0]               k;
  logic [3:0]               j;
  logic [1:0]               row;
  logic signed [Q_W-1:0]    qa, qb;
  logic signed [26:0]       rx, ry, rz;
  logic [TIME_W-1:0]        gap;
  logic                     push_fire;

  // round to nearest, ties away from zero, by 2^ROT_SHIFT
  function automatic logic signed [26:0] rnd_rot(input logic signed [53:0] s);
    logic [53:0] mag;
    logic [53:0] qm;
    mag = s[53] ? 54'(-s) : 54'(s);
    qm  = (mag + (54'd1 << (ROT_SHIFT-1))) >> ROT_SHIFT;
    return s[53] ? -$signed(27'(qm)) : $signed(27'(qm));
  endfunction

  assign in_ready  = (state_r == F_IDLE);
  assign push_fire = (state_r == F_PUSH) && push_ready;
  assign k         = step_r[3:0];
  assign j         = 4'(step_r - 5'd9);

  // quaternion products widened for the matrix terms
  always_comb begin
    for (int i = 0; i < NUM_QP; i++) pe[i] = 34'(p_r[i]);
  end

  // operand select for the shared multiplier
  always_comb begin
    qa    = '0;
    qb    = '0;
    mul_a = '0;
    mul_b = '0;
    row   = 2'd0;
    if (state_r == F_QPROD) begin
      unique case (QP_A[k])
        QS_W: qa = qw_r;
        QS_X: qa = qx_r;
        QS_Y: qa = qy_r;
        QS_Z: qa = qz_r;
      endcase
      unique case (QP_B[k])
        QS_W: qb = qw_r;
        QS_X: qb = qx_r;
        QS_Y: qb = qy_r;
        QS_Z: qb = qz_r;
      endcase
      mul_a = 34'(qa);
      mul_b = ACC_W'(qb);
    end else begin
      // matrix entry (off identity) times body acceleration
      case (j)
        4'd0: begin mul_a = -((pe[1] + pe[2]) <<< 1); mul_b = ax_r; row = 2'd0; end
        4'd1: begin mul_a =  ((pe[3] - pe[8]) <<< 1); mul_b = ay_r; row = 2'd0; end
        4'd2: begin mul_a =  ((pe[4] + pe[7]) <<< 1); mul_b = az_r; row = 2'd0; end
        4'd3: begin mul_a =  ((pe[3] + pe[8]) <<< 1); mul_b = ax_r; row = 2'd1; end
        4'd4: begin mul_a = -((pe[0] + pe[2]) <<< 1); mul_b = ay_r; row = 2'd1; end
        4'd5: begin mul_a =  ((pe[5] - pe[6]) <<< 1); mul_b = az_r; row = 2'd1; end
        4'd6: begin mul_a =  ((pe[4] - pe[7]) <<< 1); mul_b = ax_r; row = 2'd2; end
        4'd7: begin mul_a =  ((pe[5] + pe[6]) <<< 1); mul_b = ay_r; row = 2'd2; end
        4'd8: begin mul_a = -((pe[0] + pe[1]) <<< 1); mul_b = az_r; row = 2'd2; end
        default: begin mul_a = '0; mul_b = '0; row = 2'd0; end
      endcase
    end
    prod = mul_a * mul_b;
  end

  // world acceleration, gap check and queued item
  always_comb begin
    rx  = rnd_rot(sx_r);
    ry  = rnd_rot(sy_r);
    rz  = rnd_rot(sz_r);
    gap = ts_r - last_ts_r;
    push_item.wx   = sat_acc(28'(ax_r) + 28'(rx));
    push_item.wy   = sat_acc(28'(ay_r) + 28'(ry));
    push_item.wz   = sat_acc(28'(az_r) + 28'(rz) - 28'(GRAVITY_MM));
    push_item.baro = baro_r;
    push_item.dt   = gap[GAP_W-1:0];
    if (!started_r) push_item.status = ST_INIT;
    else if (gap == '0 || gap > TIME_W'(max_gap)) push_item.status = ST_SKIP;
    else push_item.status = ST_UPDATE;
    push_valid = (state_r == F_PUSH);
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_QPROD;
      F_QPROD: if (step_r == 5'd8) state_nxt = F_ROT;
      F_ROT:   if (step_r == 5'd17) state_nxt = F_PUSH;
      F_PUSH:  if (push_ready) state_nxt = F_IDLE;
    endcase
  end

  // control and time state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      started_r <= 1'b0;
      last_ts_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (push_fire) begin
        started_r <= 1'b1;
        last_ts_r <= ts_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          ax_r   <= in_body_accel_x;
          ay_r   <= in_body_accel_y;
          az_r   <= in_body_accel_z;
          qw_r   <= in_quat_w;
          qx_r   <= in_quat_x;
          qy_r   <= in_quat_y;
          qz_r   <= in_quat_z;
          baro_r <= in_baro_altitude_mm;
          ts_r   <= in_timestamp_us;
          step_r <= '0;
          sx_r   <= '0;
          sy_r   <= '0;
          sz_r   <= '0;
        end
      end
      F_QPROD: begin
        p_r[k] <= prod[31:0];
        step_r <= step_r + 5'd1;
      end
      F_ROT: begin
        unique case (row)
          2'd0:    sx_r <= sx_r + 54'(prod);
          2'd1:    sy_r <= sy_r + 54'(prod);
          default: sz_r <= sz_r + 54'(prod);
        endcase
        step_r <= step_r + 5'd1;
      end
      F_PUSH: begin
      end
    endcase
  end

endmodule

/* rtl/vafu_div.sv */
// ----------------------------------------------------------------------------
// vafu_div
// Signed by unsigned divider, rounding to nearest with ties away from zero.
// Radix 4, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module vafu_div
  import vafu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] dividend,
  input  logic [ALT_W-1:0]        divisor,
  output logic                    done,
  output logic signed [DIV_W:0]   quotient
);

  logic                busy_r;
  logic                done_r;
  logic [4:0]          cnt_r;
  logic [ALT_W-1:0]    rem_r;
  logic [ALT_W-1:0]    dvs_r;
  logic [DIV_W-1:0]    quo_r;
  logic                neg_r;

  logic [DIV_W-1:0]    mag;
  logic [ALT_W:0]      t1, t2;
  logic                ge1, ge2;
  logic [ALT_W-1:0]    r1, r2;

  // magnitude plus half the divisor gives round half away
  assign mag = (dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend))
               + DIV_W'(divisor >> 1);

  // two restoring steps per cycle
  always_comb begin
    t1  = {rem_r, quo_r[DIV_W-1]};
    ge1 = (t1 >= {1'b0, dvs_r});
    r1  = ge1 ? ALT_W'(t1 - {1'b0, dvs_r}) : t1[ALT_W-1:0];
    t2  = {r1, quo_r[DIV_W-2]};
    ge2 = (t2 >= {1'b0, dvs_r});
    r2  = ge2 ? ALT_W'(t2 - {1'b0, dvs_r}) : t2[ALT_W-1:0];
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == 5'(DIV_STEPS-1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS-1)) busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[DIV_W-1];
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-3:0], ge1, ge2};
      rem_r <= r2;
    end
  end

endmodule

/* rtl/vafu_back.sv */
// ----------------------------------------------------------------------------
// vafu_back
// Runs the three complementary blends for each queued update item with one shared
// multiplier and one shared divider, and holds the result register.
// ----------------------------------------------------------------------------
module vafu_back
  import vafu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     pop_valid,
  input  fq_item_t                 pop_item,
  output logic                     pop_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WACC_W-1:0] out_world_accel_x,
  output logic signed [WACC_W-1:0] out_world_accel_y,
  output logic signed [WACC_W-1:0] out_world_accel_z,
  output logic signed [VEL_W-1:0]  out_baro_speed_mm_s,
  output logic signed [VEL_W-1:0]  out_fused_velocity_mm_s,
  output logic signed [ALT_W-1:0]  out_fused_altitude_mm,
  output logic [1:0]               out_update_status
);

  back_state_t state_r, state_nxt;
  phase_t      phase_r;
  fq_item_t    ent_r;

  logic signed [ALT_W-1:0]  last_baro_r;
  logic signed [VEL_W-1:0]  speed_r;
  logic signed [VEL_W-1:0]  vel_r;
  logic signed [ALT_W-1:0]  alt_r;
  logic signed [23:0]       imu_r;
  logic signed [26:0]       pred_r;
  logic signed [53:0]       prod_r;
  logic signed [53:0]       acc_r;
  logic                     out_valid_r;
  logic signed [WACC_W-1:0] out_wx_r, out_wy_r, out_wz_r;
  logic signed [VEL_W-1:0]  out_spd_r, out_vel_r;
  logic signed [ALT_W-1:0]  out_alt_r;
  status_t                  out_st_r;

  logic signed [26:0]       mul_a, mul_b;
  logic signed [53:0]       prod;
  logic signed [53:0]       dsum;
  logic signed [25:0]       diff;
  logic signed [26:0]       dt_s;
  logic [ALT_W-1:0]         divisor;
  logic                     div_done;
  logic signed [DIV_W:0]    quo;
  logic                     two_mul;
  logic                     out_free;

  assign pop_ready = (state_r == B_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign diff      = 26'($signed(ent_r.baro)) - 26'(last_baro_r);
  assign dt_s      = $signed({7'd0, ent_r.dt});
  assign dsum      = acc_r + prod_r;
  assign two_mul   = (phase_r == P_SPD) || (phase_r == P_VEL) || (phase_r == P_ALT);

  // multiplier operands and divisor per phase
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    divisor = ALT_W'(US_PER_S);
    if (state_r == B_MUL2) begin
      case (phase_r)
        P_SPD:   begin mul_a = 27'(diff); mul_b = 27'(US_PER_S); end
        P_VEL:   begin mul_a = dt_s; mul_b = 27'(speed_r); end
        P_ALT:   begin mul_a = dt_s; mul_b = 27'($signed(ent_r.baro)); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      unique case (phase_r)
        P_SPD: begin mul_a = $signed({3'd0, cfg.tau_baro}); mul_b = 27'(speed_r); end
        P_IMU: begin mul_a = 27'($signed(ent_r.wz)); mul_b = dt_s; end
        P_VEL: begin mul_a = $signed({3'd0, cfg.tau_vel}); mul_b = 27'(imu_r); end
        P_PRD: begin mul_a = 27'(vel_r); mul_b = dt_s; end
        P_ALT: begin mul_a = $signed({3'd0, cfg.tau_alt}); mul_b = pred_r; end
      endcase
    end
    unique case (phase_r)
      P_SPD:         divisor = ALT_W'(cfg.tau_baro) + ALT_W'(ent_r.dt);
      P_VEL:         divisor = ALT_W'(cfg.tau_vel) + ALT_W'(ent_r.dt);
      P_ALT:         divisor = ALT_W'(cfg.tau_alt) + ALT_W'(ent_r.dt);
      P_IMU, P_PRD:  divisor = ALT_W'(US_PER_S);
    endcase
    prod = mul_a * mul_b;
  end

  vafu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == B_DSTART),
    .dividend ($signed(dsum[DIV_W-1:0])),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (pop_valid) state_nxt = B_CLASS;
      B_CLASS:  state_nxt = (ent_r.status == ST_UPDATE) ? B_MUL1 : B_OUT;
      B_MUL1:   state_nxt = two_mul ? B_MUL2 : B_DSTART;
      B_MUL2:   state_nxt = B_DSTART;
      B_DSTART: state_nxt = B_DWAIT;
      B_DWAIT:  if (div_done) state_nxt = (phase_r == P_ALT) ? B_OUT : B_MUL1;
      B_OUT:    if (out_free) state_nxt = B_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      phase_r     <= P_SPD;
      out_valid_r <= 1'b0;
      last_baro_r <= '0;
      speed_r     <= '0;
      vel_r       <= '0;
      alt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      // result valid: set on load, cleared once taken
      if (state_r == B_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        B_CLASS: begin
          phase_r <= P_SPD;
          if (ent_r.status == ST_INIT) begin
            vel_r       <= '0;
            alt_r       <= sat_alt((DIV_W+1)'($signed(ent_r.baro)));
            last_baro_r <= ent_r.baro;
          end
        end
        B_DWAIT: begin
          if (div_done) begin
            unique case (phase_r)
              P_SPD: begin speed_r <= sat_vel(quo); phase_r <= P_IMU; end
              P_IMU: phase_r <= P_VEL;
              P_VEL: begin vel_r <= sat_vel(quo); phase_r <= P_PRD; end
              P_PRD: phase_r <= P_ALT;
              P_ALT: begin alt_r <= sat_alt(quo); last_baro_r <= ent_r.baro; end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && pop_valid) ent_r <= pop_item;
    if (state_r == B_MUL1) begin
      prod_r <= prod;
      acc_r  <= '0;
    end
    if (state_r == B_MUL2) begin
      prod_r <= prod;
      acc_r  <= prod_r;
    end
    if (state_r == B_DWAIT && div_done) begin
      if (phase_r == P_IMU) imu_r  <= 24'(vel_r) + $signed(quo[23:0]);
      if (phase_r == P_PRD) pred_r <= 27'(alt_r) + $signed(quo[26:0]);
    end
    if (state_r == B_OUT && out_free) begin
      out_wx_r  <= ent_r.wx;
      out_wy_r  <= ent_r.wy;
      out_wz_r  <= ent_r.wz;
      out_spd_r <= speed_r;
      out_vel_r <= vel_r;
      out_alt_r <= alt_r;
      out_st_r  <= ent_r.status;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_world_accel_x       = out_wx_r;
  assign out_world_accel_y       = out_wy_r;
  assign out_world_accel_z       = out_wz_r;
  assign out_baro_speed_mm_s     = out_spd_r;
  assign out_fused_velocity_mm_s = out_vel_r;
  assign out_fused_altitude_mm   = out_alt_r;
  assign out_update_status       = out_st_r;

endmodule

/* rtl/vertical_altitude_velocity_fusion_unit.sv */
// ----------------------------------------------------------------------------
// vertical_altitude_velocity_fusion_unit
// Complementary filter for vertical velocity and altitude from IMU
// acceleration, attitude quaternion and barometric altitude.
//
//   port group   direction   handshake            contents
//   in_*         input       in_valid/in_ready    accel, quaternion, baro, time
//   out_*        output      out_valid/out_ready  world accel, speed, vel, alt
//   cfg_*        input       cfg_wr_en            time constants, max gap
//
// Front: 9 quaternion products, then 9 matrix terms on one multiplier,
// then the queue push. Back: an initial or skipped item goes straight to
// the result state; an update runs five divisions on the shared radix-4
// divider. A two-entry queue decouples the two; a stalled output holds
// the back in its result state.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module vertical_altitude_velocity_fusion_unit
  import vafu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ACC_W-1:0]  in_body_accel_x,
  input  logic signed [ACC_W-1:0]  in_body_accel_y,
  input  logic signed [ACC_W-1:0]  in_body_accel_z,
  input  logic signed [Q_W-1:0]    in_quat_w,
  input  logic signed [Q_W-1:0]    in_quat_x,
  input  logic signed [Q_W-1:0]    in_quat_y,
  input  logic signed [Q_W-1:0]    in_quat_z,
  input  logic signed [ALT_W-1:0]  in_baro_altitude_mm,
  input  logic [TIME_W-1:0]        in_timestamp_us,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WACC_W-1:0] out_world_accel_x,
  output logic signed [WACC_W-1:0] out_world_accel_y,
  output logic signed [WACC_W-1:0] out_world_accel_z,
  output logic signed [VEL_W-1:0]  out_baro_speed_mm_s,
  output logic signed [VEL_W-1:0]  out_fused_velocity_mm_s,
  output logic signed [ALT_W-1:0]  out_fused_altitude_mm,
  output logic [1:0]               out_update_status,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_index,
  input  logic [TAU_W-1:0]         cfg_wdata
);

  cfg_t     cfg_r;
  logic     push_valid;
  fq_item_t push_item;
  logic     fq_full;
  logic     fq_empty;
  fq_item_t fq_head;
  logic     pop_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tau_baro <= TAU_W'(100000);
      cfg_r.tau_vel  <= TAU_W'(500000);
      cfg_r.tau_alt  <= TAU_W'(500000);
      cfg_r.max_gap  <= GAP_W'(100000);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TAU_BARO: cfg_r.tau_baro <= cfg_wdata;
        CFG_TAU_VEL:  cfg_r.tau_vel  <= cfg_wdata;
        CFG_TAU_ALT:  cfg_r.tau_alt  <= cfg_wdata;
        CFG_MAX_GAP:  cfg_r.max_gap  <= cfg_wdata[GAP_W-1:0];
      endcase
    end
  end

  vafu_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_body_accel_x     (in_body_accel_x),
    .in_body_accel_y     (in_body_accel_y),
    .in_body_accel_z     (in_body_accel_z),
    .in_quat_w           (in_quat_w),
    .in_quat_x           (in_quat_x),
    .in_quat_y           (in_quat_y),
    .in_quat_z           (in_quat_z),
    .in_baro_altitude_mm (in_baro_altitude_mm),
    .in_timestamp_us     (in_timestamp_us),
    .max_gap             (cfg_r.max_gap),
    .push_valid          (push_valid),
    .push_item           (push_item),
    .push_ready          (!fq_full)
  );

  vafu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_item (push_item),
    .full      (fq_full),
    .pop       (pop_ready),
    .empty     (fq_empty),
    .head      (fq_head)
  );

  vafu_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg_r),
    .pop_valid               (!fq_empty),
    .pop_item                (fq_head),
    .pop_ready               (pop_ready),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_world_accel_x       (out_world_accel_x),
    .out_world_accel_y       (out_world_accel_y),
    .out_world_accel_z       (out_world_accel_z),
    .out_baro_speed_mm_s     (out_baro_speed_mm_s),
    .out_fused_velocity_mm_s (out_fused_velocity_mm_s),
    .out_fused_altitude_mm   (out_fused_altitude_mm),
    .out_update_status       (out_update_status)
  );

endmodule

/* rtl/vafu_checker.sv */
// ----------------------------------------------------------------------------
// vafu_checker
// Port-level checks on the fusion unit's result channel.
// ----------------------------------------------------------------------------
module vafu_checker
  import vafu_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [WACC_W-1:0] out_world_accel_z,
  input logic signed [VEL_W-1:0]  out_fused_velocity_mm_s,
  input logic signed [ALT_W-1:0]  out_fused_altitude_mm
);

  // stalled result stays valid and its altitude holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fused_altitude_mm))
    else $error("stalled result changed");

  // no result straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // fused velocity saturates
  a_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fused_velocity_mm_s >= -VEL_LIM && out_fused_velocity_mm_s <= VEL_LIM)
    else $error("fused velocity out of range");

  // altitude and vertical acceleration saturate
  a_alt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fused_altitude_mm >= ALT_LO && out_fused_altitude_mm <= ALT_HI
      && out_world_accel_z >= -ACC_LIM && out_world_accel_z <= ACC_LIM)
    else $error("altitude or acceleration out of range");

endmodule

bind vertical_altitude_velocity_fusion_unit vafu_checker u_vafu_checker (.*);

/* verif/tb_vertical_altitude_velocity_fusion_unit.sv */
// ----------------------------------------------------------------------------
// tb_vertical_altitude_velocity_fusion_unit
// Self-checking bench for the altitude/velocity complementary filter. A table
// of directed samples covers seeding, bad time gaps, timestamp wrap and field
// extremes. Random phases follow under several filter settings, with random stalls
// on both channels except in one calm phase. Untyped results are compared against an
// in-bench integer model of the rotation, gravity removal and the three blends.
// ----------------------------------------------------------------------------
module tb_vertical_altitude_velocity_fusion_unit;
  import vafu_pkg::*;

  typedef struct {
    logic signed [ACC_W-1:0] ax, ay, az;
    logic signed [Q_W-1:0]   qw, qx, qy, qz;
    logic signed [ALT_W-1:0] baro;
    logic [TIME_W-1:0]       ts;
  } imu_sample_t;

  typedef struct {
    logic signed [WACC_W-1:0] wx, wy, wz;
    logic signed [VEL_W-1:0]  speed, vel;
    logic signed [ALT_W-1:0]  alt;
    status_t                  status;
  } fusion_out_t;

  typedef struct {
    imu_sample_t s;
    bit          typed;
    fusion_out_t r;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [ACC_W-1:0]  in_body_accel_x, in_body_accel_y, in_body_accel_z;
  logic signed [Q_W-1:0]    in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic signed [ALT_W-1:0]  in_baro_altitude_mm;
  logic [TIME_W-1:0]        in_timestamp_us;
  logic signed [WACC_W-1:0] out_world_accel_x, out_world_accel_y, out_world_accel_z;
  logic signed [VEL_W-1:0]  out_baro_speed_mm_s, out_fused_velocity_mm_s;
  logic signed [ALT_W-1:0]  out_fused_altitude_mm;
  logic [1:0]               out_update_status;
  logic                     cfg_wr_en;
  logic [1:0]               cfg_index;
  logic [TAU_W-1:0]         cfg_wdata;

  vertical_altitude_velocity_fusion_unit dut (.*);

  // filter model state and settings
  longint      tau_b, tau_v, tau_a, gap_max;
  bit          seeded;
  logic [31:0] prev_ts;
  longint      prev_baro, baro_speed, fused_vel, fused_alt;

  fusion_out_t expected_fusion_q[$];
  int          errors;
  bit          calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #(40_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // divide rounding to nearest, ties away from zero
  function automatic longint round_div(longint n, longint d);
    longint mag;
    longint q;
    mag = n < 0 ? -n : n;
    q = (mag + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint round_rot(longint n);
    longint mag;
    longint q;
    mag = n < 0 ? -n : n;
    q = (mag + (64'sd1 <<< (ROT_SHIFT - 1))) >>> ROT_SHIFT;
    return n < 0 ? -q : q;
  endfunction

  // advance the filter model by one sample
  function automatic fusion_out_t fuse_sample(imu_sample_t s);
    fusion_out_t r;
    longint ax, ay, az, qw, qx, qy, qz, baro, sx, sy, sz, wz, dt, imu, pred;
    logic [31:0] gap;
    ax = s.ax; ay = s.ay; az = s.az;
    qw = s.qw; qx = s.qx; qy = s.qy; qz = s.qz;
    baro = s.baro;
    sx = -2 * (qy * qy + qz * qz) * ax + 2 * (qx * qy - qz * qw) * ay
         + 2 * (qx * qz + qy * qw) * az;
    sy = 2 * (qx * qy + qz * qw) * ax - 2 * (qx * qx + qz * qz) * ay
         + 2 * (qy * qz - qx * qw) * az;
    sz = 2 * (qx * qz - qy * qw) * ax + 2 * (qy * qz + qx * qw) * ay
         - 2 * (qx * qx + qy * qy) * az;
    r.wx = clamp(ax + round_rot(sx), -ACC_LIM, ACC_LIM);
    r.wy = clamp(ay + round_rot(sy), -ACC_LIM, ACC_LIM);
    wz = clamp(az + round_rot(sz) - GRAVITY_MM, -ACC_LIM, ACC_LIM);
    r.wz = wz;
    if (!seeded) begin
      prev_ts = s.ts;
      prev_baro = baro;
      fused_vel = 0;
      fused_alt = clamp(baro, ALT_LO, ALT_HI);
      seeded = 1'b1;
      r.status = ST_INIT;
    end else begin
      gap = s.ts - prev_ts;
      prev_ts = s.ts;
      if (gap == 0 || gap > gap_max) begin
        r.status = ST_SKIP;
      end else begin
        dt = gap;
        baro_speed = clamp(round_div(tau_b * baro_speed + (baro - prev_baro) * US_PER_S,
                                     tau_b + dt), -VEL_LIM, VEL_LIM);
        prev_baro = baro;
        imu = fused_vel + round_div(wz * dt, US_PER_S);
        fused_vel = clamp(round_div(tau_v * imu + dt * baro_speed, tau_v + dt),
                          -VEL_LIM, VEL_LIM);
        pred = fused_alt + round_div(fused_vel * dt, US_PER_S);
        fused_alt = clamp(round_div(tau_a * pred + dt * baro, tau_a + dt), ALT_LO, ALT_HI);
        r.status = ST_UPDATE;
      end
    end
    r.speed = baro_speed;
    r.vel = fused_vel;
    r.alt = fused_alt;
    return r;
  endfunction

  function automatic imu_sample_t mk(longint ax, longint ay, longint az, longint qw,
                                     longint qx, longint qy, longint qz, longint baro,
                                     longint ts);
    imu_sample_t s;
    s.ax = ax; s.ay = ay; s.az = az;
    s.qw = qw; s.qx = qx; s.qy = qy; s.qz = qz;
    s.baro = baro; s.ts = ts;
    return s;
  endfunction

  function automatic fusion_out_t mk_out(longint wz, longint alt, status_t st);
    fusion_out_t r;
    r.wx = 0; r.wy = 0; r.wz = wz;
    r.speed = 0; r.vel = 0; r.alt = alt; r.status = st;
    return r;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [TAU_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_TAU_BARO: tau_b = val;
      CFG_TAU_VEL:  tau_v = val;
      CFG_TAU_ALT:  tau_a = val;
      CFG_MAX_GAP:  gap_max = val[GAP_W-1:0];
    endcase
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain();
    in_valid = 1'b0;
    while (expected_fusion_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // offer one item; typed rows carry their own expectation
  task automatic send_sample(imu_sample_t s, bit typed, fusion_out_t typed_r);
    fusion_out_t r;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_body_accel_x = s.ax; in_body_accel_y = s.ay; in_body_accel_z = s.az;
    in_quat_w = s.qw; in_quat_x = s.qx; in_quat_y = s.qy; in_quat_z = s.qz;
    in_baro_altitude_mm = s.baro;
    in_timestamp_us = s.ts;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    r = fuse_sample(s);
    expected_fusion_q.push_back(typed ? typed_r : r);
    @(negedge clk);
  endtask

  // result side stalls
  always @(negedge clk) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    fusion_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_fusion_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        e = expected_fusion_q.pop_front();
        check_field("world_accel_x", e.wx, out_world_accel_x);
        check_field("world_accel_y", e.wy, out_world_accel_y);
        check_field("world_accel_z", e.wz, out_world_accel_z);
        check_field("baro_speed_mm_s", e.speed, out_baro_speed_mm_s);
        check_field("fused_velocity_mm_s", e.vel, out_fused_velocity_mm_s);
        check_field("fused_altitude_mm", e.alt, out_fused_altitude_mm);
        check_field("update_status", e.status, out_update_status);
      end
    end
  end

  // random sample: mostly in range with a drifting altitude, some raw noise
  function automatic imu_sample_t random_sample(logic [31:0] ts, longint baro);
    imu_sample_t s;
    if ($urandom_range(9) < 8) begin
      s = mk($signed($urandom_range(320000)) - 160000, $signed($urandom_range(320000)) - 160000,
             $signed($urandom_range(320000)) - 160000, $signed($urandom_range(32768)) - 16384,
             $signed($urandom_range(32768)) - 16384, $signed($urandom_range(32768)) - 16384,
             $signed($urandom_range(32768)) - 16384, baro, ts);
    end else begin
      s.ax = $urandom; s.ay = $urandom; s.az = $urandom;
      s.qw = $urandom; s.qx = $urandom; s.qy = $urandom; s.qz = $urandom;
      s.baro = $urandom;
      s.ts = ts;
    end
    return s;
  endfunction

  initial begin
    stim_row_t   rows[$];
    stim_row_t   row;
    fusion_out_t none;
    logic [31:0] ts;
    longint      baro, dt;
    int          n;
    longint      phase_cfg[5][4] = '{
      '{1, 1, 1, 1000000},
      '{0, 0, 0, 1},
      '{10000000, 10000000, 10000000, 1000000},
      '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
      '{5000, 200000, 800000, 20000}
    };

    rst_n = 1'b0; in_valid = 1'b0; cfg_wr_en = 1'b0; cfg_index = CFG_TAU_BARO;
    cfg_wdata = '0; calm = 1'b0; errors = 0;
    in_body_accel_x = '0; in_body_accel_y = '0; in_body_accel_z = '0;
    in_quat_w = '0; in_quat_x = '0; in_quat_y = '0; in_quat_z = '0;
    in_baro_altitude_mm = '0; in_timestamp_us = '0;
    tau_b = 100000; tau_v = 500000; tau_a = 500000; gap_max = 100000;
    seeded = 1'b0; prev_ts = 0; prev_baro = 0; baro_speed = 0; fused_vel = 0; fused_alt = 0;
    none = mk_out(0, 0, ST_INIT);

    // directed table
    row.typed = 1'b1;
    row.s = mk(0, 0, 9810, 16384, 0, 0, 0, 1000, 1000);
    row.r = mk_out(0, 1000, ST_INIT); rows.push_back(row);
    row.s.ts = 1000;  // zero gap
    row.r = mk_out(0, 1000, ST_SKIP); rows.push_back(row);
    row.s.ts = 101001;  // one past the largest gap
    rows.push_back(row);
    row.typed = 1'b0;
    row.s.ts = 201001; row.s.baro = 1500; rows.push_back(row);  // largest gap
    row.s = mk(160000, 160000, 160000, 16384, 0, 0, 0, 2000, 211001); rows.push_back(row);
    row.s = mk(-160000, -160000, -160000, 16384, 0, 0, 0, 1000, 221001); rows.push_back(row);
    row.s = mk(100000, -50000, 9810, 0, 16384, 0, 0, 900, 231001); rows.push_back(row);
    row.s = mk(100000, -50000, 9810, 0, 0, 16384, 0, 900, 241001); rows.push_back(row);
    row.s = mk(100000, -50000, 9810, 0, 0, 0, 16384, 900, 251001); rows.push_back(row);
    row.s = mk(160000, -160000, 160000, -16384, -16384, -16384, -16384, 800, 261001);
    rows.push_back(row);
    row.s = mk(-160000, 160000, -160000, 16384, 16384, 16384, 16384, 800, 271001);
    rows.push_back(row);
    row.s = mk(262143, -262144, 262143, 32767, -32768, 32767, -32768, 16000000, 281001);
    rows.push_back(row);
    row.s = mk(-262144, 262143, -262144, -32768, 32767, -32768, 32767, -1000000, 291001);
    rows.push_back(row);
    row.s = mk(0, 0, 9810, 16384, 0, 0, 0, 16777215, 301001); rows.push_back(row);
    row.s = mk(0, 0, 9810, 16384, 0, 0, 0, -16777216, 311001); rows.push_back(row);
    row.s = mk(0, 0, 9810, 16384, 0, 0, 0, 5000, 32'hFFFFFFF0); rows.push_back(row);
    row.s = mk(0, 0, 9810, 16384, 0, 0, 0, 5100, 32'h00000010); rows.push_back(row);  // wrap
    row.s = mk(11585, 0, 9810, 11585, 0, 11585, 0, 5200, 32'h00002720); rows.push_back(row);

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_sample(rows[i].s, rows[i].typed, rows[i].r);
    drain();

    // random phases, each under its own filter settings
    ts = prev_ts;
    baro = 5000;
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_TAU_BARO, phase_cfg[p][0]);
      write_reg(CFG_TAU_VEL, phase_cfg[p][1]);
      write_reg(CFG_TAU_ALT, phase_cfg[p][2]);
      write_reg(CFG_MAX_GAP, phase_cfg[p][3]);
      calm = (p == 2);
      n = 0;
      while (n < 100) begin
        if ($urandom_range(9) == 0) begin
          ts = $urandom_range(4) == 0 ? ts : $urandom;  // bad or random jump
        end else begin
          dt = $urandom_range(3) == 0 ? gap_max : $urandom_range(gap_max, 1);
          ts = ts + dt[31:0];
        end
        baro = $urandom_range(19) == 0 ? $signed($urandom_range(17000000)) - 1000000
                                       : clamp(baro + $signed($urandom_range(4000)) - 2000,
                                               ALT_LO, ALT_HI);
        send_sample(random_sample(ts, baro), 1'b0, none);
        n++;
        if (n == 50 && p == 1) drain();
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0 && expected_fusion_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (expected_fusion_q.size() != 0) $error("%0d results never arrived",
                                                expected_fusion_q.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* vertical_altitude_velocity_fusion_unit.f */
rtl/vafu_pkg.sv
rtl/vafu_fifo.sv
rtl/vafu_front.sv
rtl/vafu_div.sv
rtl/vafu_back.sv
rtl/vertical_altitude_velocity_fusion_unit.sv
rtl/vafu_checker.sv
verif/tb_vertical_altitude_velocity_fusion_unit.sv
